[src/led_palette_animator_top_macros.svh]
// Assertion macros shared by the palette animator modules.
`ifndef LED_PALETTE_ANIMATOR_TOP_MACROS_SVH
`define LED_PALETTE_ANIMATOR_TOP_MACROS_SVH

// Consequent must hold on the clock edge after the antecedent.
`define LPA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("palette animator assertion failed");

// Consequent must hold on the same clock edge as the antecedent.
`define LPA_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("palette animator assertion failed");

`endif

[src/lpa_pkg.sv]
// Shared types, codes and constants of the LED palette animator.
package lpa_pkg;

   localparam int DEF_MAX_LEDS      = 64;
   localparam int DEF_PALETTE_DEPTH = 16;

   localparam int DIV_STEPS = 32;
   localparam int COUNT_W   = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD_MS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_SIZE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LED_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_TIME   = 3'd4;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   localparam logic MODE_JUMP   = 1'b0;
   localparam logic MODE_SCROLL = 1'b1;

   localparam logic [15:0] RST_PERIOD_MS    = 16'd1000;
   localparam logic [4:0]  RST_PALETTE_SIZE = 5'd1;
   localparam logic [6:0]  RST_LED_COUNT    = 7'd1;
   localparam logic [31:0] RST_START_TIME   = 32'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_MID,
      ST_DIV2,
      ST_START,
      ST_SHOW
   } lpa_state_type;

   typedef struct packed {
      logic pal_write;
      logic load_div1;
      logic div_step;
      logic load_div2;
      logic start_leds;
      logic advance;
   } lpa_cmd_type;

   typedef struct packed {
      logic last_led;
   } lpa_status_type;

endpackage

[src/lpa_ctrl.sv]
// Sequencer for the palette animator: divisions, then one LED per cycle while responses are taken.
`include "led_palette_animator_top_macros.svh"

module lpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lpa_pkg::lpa_status_type status,
   output lpa_pkg::lpa_cmd_type    cmd
);

   localparam logic [lpa_pkg::COUNT_W-1:0] COUNT_LAST =
      lpa_pkg::COUNT_W'(lpa_pkg::DIV_STEPS - 1);

   lpa_pkg::lpa_state_type state_ff, state_in;
   logic [lpa_pkg::COUNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpa_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lpa_pkg::ST_IDLE: begin
            // No request is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               if (req_command == lpa_pkg::CMD_RENDER) begin
                  cmd.load_div1 = 1'b1;
                  count_in      = '0;
                  state_in      = lpa_pkg::ST_DIV1;
               end else begin
                  cmd.pal_write = 1'b1;
               end
            end
         end
         lpa_pkg::ST_DIV1: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == COUNT_LAST) begin
               state_in = lpa_pkg::ST_MID;
            end
         end
         lpa_pkg::ST_MID: begin
            cmd.load_div2 = 1'b1;
            count_in      = '0;
            state_in      = lpa_pkg::ST_DIV2;
         end
         lpa_pkg::ST_DIV2: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == COUNT_LAST) begin
               state_in = lpa_pkg::ST_START;
            end
         end
         lpa_pkg::ST_START: begin
            cmd.start_leds = 1'b1;
            state_in       = lpa_pkg::ST_SHOW;
         end
         lpa_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last_led) begin
                  state_in = lpa_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = lpa_pkg::ST_IDLE;
         end
      endcase
   end

   `LPA_ASSERT_NEXT(a_render_starts_div, clock, reset,
      req_valid && req_ready && req_command == lpa_pkg::CMD_RENDER,
      state_ff == lpa_pkg::ST_DIV1 && count_ff == '0)
   `LPA_ASSERT_NEXT(a_div2_then_start, clock, reset,
      state_ff == lpa_pkg::ST_DIV2 && count_ff == COUNT_LAST,
      state_ff == lpa_pkg::ST_START)
   `LPA_ASSERT_NEXT(a_last_ends_frame, clock, reset,
      rsp_valid && rsp_ready && status.last_led,
      state_ff == lpa_pkg::ST_IDLE && req_ready)

endmodule

[src/lpa_dp.sv]
// Datapath: settings, palette memory, shared serial divider and LED counters.
`include "led_palette_animator_top_macros.svh"

module lpa_dp #(
   parameter int MAX_LEDS      = lpa_pkg::DEF_MAX_LEDS,
   parameter int PALETTE_DEPTH = lpa_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [lpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lpa_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic [31:0]                       req_now_ms,
   input  logic [3:0]                        req_entry_index,
   input  logic [7:0]                        req_entry_hue,
   input  logic [7:0]                        req_entry_sat,
   input  logic [7:0]                        req_entry_val,
   input  lpa_pkg::lpa_cmd_type              cmd,
   output lpa_pkg::lpa_status_type           status,
   output logic [5:0]                        rsp_led_index,
   output logic [7:0]                        rsp_hue,
   output logic [7:0]                        rsp_sat,
   output logic [7:0]                        rsp_val,
   output logic                              rsp_last
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam logic [4:0] SIZE_CAP = (PALETTE_DEPTH > 31) ? 5'd31 : 5'(PALETTE_DEPTH);
   localparam logic [6:0] LED_CAP  = 7'(MAX_LEDS);

   // Settings.
   logic        mode_ff;
   logic [15:0] period_ff;
   logic [4:0]  size_ff;
   logic [6:0]  leds_ff;
   logic [31:0] start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lpa_pkg::MODE_JUMP;
         period_ff <= lpa_pkg::RST_PERIOD_MS;
         size_ff   <= lpa_pkg::RST_PALETTE_SIZE;
         leds_ff   <= lpa_pkg::RST_LED_COUNT;
         start_ff  <= lpa_pkg::RST_START_TIME;
      end else if (csr_write_en) begin
         case (csr_index)
            lpa_pkg::REG_MODE:         mode_ff   <= csr_write_data[0];
            lpa_pkg::REG_PERIOD_MS:    period_ff <= csr_write_data[15:0];
            lpa_pkg::REG_PALETTE_SIZE: size_ff   <= csr_write_data[4:0];
            lpa_pkg::REG_LED_COUNT:    leds_ff   <= csr_write_data[6:0];
            lpa_pkg::REG_START_TIME:   start_ff  <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   logic [15:0] per_eff;
   logic [4:0]  size_eff;
   logic [6:0]  leds_eff;

   always_comb begin
      per_eff  = (period_ff == '0) ? 16'd1 : period_ff;
      if (size_ff == '0) begin
         size_eff = 5'd1;
      end else if (size_ff > SIZE_CAP) begin
         size_eff = SIZE_CAP;
      end else begin
         size_eff = size_ff;
      end
      if (leds_ff == '0) begin
         leds_eff = 7'd1;
      end else if (leds_ff > LED_CAP) begin
         leds_eff = LED_CAP;
      end else begin
         leds_eff = leds_ff;
      end
   end

   // Restoring divider, one quotient bit per step. The dividend register
   // collects the quotient as its bits shift out.
   logic [31:0] dividend_ff, dividend_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] divisor_ff, divisor_in;
   logic [16:0] trial;
   logic [16:0] trial_diff;
   logic        trial_ge;
   logic [20:0] product;

   assign trial      = {rem_ff, dividend_ff[31]};
   assign trial_ge   = trial >= {1'b0, divisor_ff};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign product    = 21'(rem_ff) * 21'(size_eff);

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      if (cmd.load_div1) begin
         dividend_in = req_now_ms - start_ff;
         rem_in      = '0;
         divisor_in  = per_eff;
      end else if (cmd.load_div2) begin
         rem_in = '0;
         if (mode_ff == lpa_pkg::MODE_JUMP) begin
            dividend_in = dividend_ff;
            divisor_in  = 16'(size_eff);
         end else begin
            dividend_in = 32'(product);
            divisor_in  = per_eff;
         end
      end else if (cmd.div_step) begin
         dividend_in = {dividend_ff[30:0], trial_ge};
         rem_in      = trial_ge ? trial_diff[15:0] : trial[15:0];
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
   end

   // Palette memory and LED walk.
   logic [23:0] palette [PALETTE_DEPTH];
   logic [23:0] rd_ff;
   logic [4:0]  sel_ff;
   logic [4:0]  sel_next;
   logic [4:0]  base;
   logic [5:0]  led_ff;
   logic [AW-1:0] rd_addr;

   assign base = (mode_ff == lpa_pkg::MODE_JUMP) ? rem_ff[4:0] : dividend_ff[4:0];

   always_comb begin
      if (mode_ff == lpa_pkg::MODE_SCROLL) begin
         sel_next = (sel_ff + 5'd1 == size_eff) ? 5'd0 : sel_ff + 5'd1;
      end else begin
         sel_next = sel_ff;
      end
      rd_addr = cmd.start_leds ? AW'(base) : AW'(sel_next);
   end

   always_ff @(posedge clock) begin
      if (cmd.pal_write && 32'(req_entry_index) < PALETTE_DEPTH) begin
         palette[AW'(req_entry_index)] <= {req_entry_hue, req_entry_sat, req_entry_val};
      end
      if (cmd.start_leds || cmd.advance) begin
         rd_ff <= palette[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_leds) begin
         sel_ff <= base;
         led_ff <= '0;
      end else if (cmd.advance) begin
         sel_ff <= sel_next;
         led_ff <= led_ff + 6'd1;
      end
   end

   assign status.last_led = (7'(led_ff) + 7'd1) == leds_eff;

   assign rsp_led_index = led_ff;
   assign rsp_hue       = rd_ff[23:16];
   assign rsp_sat       = rd_ff[15:8];
   assign rsp_val       = rd_ff[7:0];
   assign rsp_last      = status.last_led;

   `LPA_ASSERT_NEXT(a_led_counts_up, clock, reset,
      cmd.advance, led_ff == $past(led_ff) + 6'd1)
   `LPA_ASSERT_NEXT(a_jump_holds_entry, clock, reset,
      cmd.advance && mode_ff == lpa_pkg::MODE_JUMP, $stable(sel_ff))

endmodule

[src/led_palette_animator_top.sv]
// Top level of the LED palette animator: controller plus datapath.
//
//   channel   direction  handshake                    payload
//   req       in         req_valid / req_ready        command, now_ms, entry_*
//   rsp       out        rsp_valid / rsp_ready        led_index, hue, sat, val, last
//   csr       in         csr_write_en (no wait)       csr_index, csr_write_data
//
// A palette write request gives no response. A render request runs two
// 32-step serial divisions on the shared divider, then one LED leaves per
// cycle from the registered palette read while responses are taken at once.
// Reset is synchronous and active high; it restores the settings and idles
// the sequencer. The palette is not cleared and holds garbage until written.
// A stalled response holds its fields; no new request is taken until the
// last LED of a frame has been delivered.
module led_palette_animator_top #(
   parameter int MAX_LEDS      = lpa_pkg::DEF_MAX_LEDS,
   parameter int PALETTE_DEPTH = lpa_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [lpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [31:0]                     req_now_ms,
   input  logic [3:0]                      req_entry_index,
   input  logic [7:0]                      req_entry_hue,
   input  logic [7:0]                      req_entry_sat,
   input  logic [7:0]                      req_entry_val,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [5:0]                      rsp_led_index,
   output logic [7:0]                      rsp_hue,
   output logic [7:0]                      rsp_sat,
   output logic [7:0]                      rsp_val,
   output logic                            rsp_last
);

   // Commands flow from the sequencer to the datapath; the datapath reports
   // back only whether the current LED is the final one of the frame.
   lpa_pkg::lpa_cmd_type    cmd;
   lpa_pkg::lpa_status_type status;

   lpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // The datapath holds the settings, the palette, the divider and the
   // response registers that stay steady while the consumer stalls.
   lpa_dp #(
      .MAX_LEDS      (MAX_LEDS),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_now_ms      (req_now_ms),
      .req_entry_index (req_entry_index),
      .req_entry_hue   (req_entry_hue),
      .req_entry_sat   (req_entry_sat),
      .req_entry_val   (req_entry_val),
      .cmd             (cmd),
      .status          (status),
      .rsp_led_index   (rsp_led_index),
      .rsp_hue         (rsp_hue),
      .rsp_sat         (rsp_sat),
      .rsp_val         (rsp_val),
      .rsp_last        (rsp_last)
   );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the LED palette animator top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The run ends here at the latest. A correct run takes well under a tenth of this.
   localparam int unsigned LIMIT_NS  = 4_000_000;
   localparam int unsigned PAL_DEPTH = 16;
   localparam int unsigned LED_MAX   = 64;

   // One request as the sender presents it. The entry fields only matter for writes,
   // and now_ms only matters for renders. Both are still driven with random content.
   typedef struct {
      logic        command;
      logic [31:0] now_ms;
      logic [3:0]  entry_index;
      logic [7:0]  entry_hue;
      logic [7:0]  entry_sat;
      logic [7:0]  entry_val;
   } lpa_request_type;

   // One LED color as the block should deliver it.
   typedef struct packed {
      logic [5:0] led_index;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      logic       last_led;
   } led_color_type;

   // Every input starts at a known value. Reset stays high until the main sequence drops it.
   logic                            clock;
   logic                            reset           = 1'b1;
   logic                            csr_write_en    = 1'b0;
   logic [lpa_pkg::CSR_INDEX_W-1:0] csr_index       = lpa_pkg::REG_MODE;
   logic [lpa_pkg::CSR_DATA_W-1:0]  csr_write_data  = '0;
   logic                            req_valid       = 1'b0;
   logic                            req_ready;
   logic                            req_command     = lpa_pkg::CMD_WRITE;
   logic [31:0]                     req_now_ms      = '0;
   logic [3:0]                      req_entry_index = '0;
   logic [7:0]                      req_entry_hue   = '0;
   logic [7:0]                      req_entry_sat   = '0;
   logic [7:0]                      req_entry_val   = '0;
   logic                            rsp_valid;
   logic                            rsp_ready       = 1'b0;
   logic [5:0]                      rsp_led_index;
   logic [7:0]                      rsp_hue;
   logic [7:0]                      rsp_sat;
   logic [7:0]                      rsp_val;
   logic                            rsp_last;

   // This is our own copy of the settings and of the palette. It is updated when a
   // register write is issued or when a request is accepted.
   logic        cfg_mode;
   logic [15:0] cfg_period;
   logic [4:0]  cfg_size;
   logic [6:0]  cfg_leds;
   logic [31:0] cfg_start;
   logic [23:0] pal_model [PAL_DEPTH];

   lpa_request_type pend_q[$];      // requests waiting for the driver
   lpa_request_type in_flight;      // request currently held on the req channel
   led_color_type   color_q[$];     // LED colors predicted but not yet delivered
   led_color_type   want;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned n_errors      = 0;
   int unsigned n_requests    = 0;
   int unsigned n_frames      = 0;
   int unsigned n_leds        = 0;
   int unsigned n_settings    = 0;

   led_palette_animator_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_now_ms     (req_now_ms),
      .req_entry_index(req_entry_index),
      .req_entry_hue  (req_entry_hue),
      .req_entry_sat  (req_entry_sat),
      .req_entry_val  (req_entry_val),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_index  (rsp_led_index),
      .rsp_hue        (rsp_hue),
      .rsp_sat        (rsp_sat),
      .rsp_val        (rsp_val),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Every mismatch goes through here. It prints one line and is counted.
   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // This works out the colors of one frame from the time stamp of a render request.
   // Out-of-range settings are clamped here: a zero period counts as one, and the palette
   // size and the LED count are forced into their legal ranges.
   function automatic void predict_leds(input logic [31:0] now);
      logic [31:0]   elapsed;
      logic [31:0]   per;
      logic [31:0]   size;
      logic [31:0]   n;
      logic [31:0]   base;
      logic [31:0]   sel;
      logic [63:0]   phase;
      led_color_type c;
      elapsed = now - cfg_start;
      per  = (cfg_period == 16'd0) ? 32'd1 : {16'd0, cfg_period};
      size = (cfg_size == 5'd0) ? 32'd1 :
             (cfg_size > 5'(PAL_DEPTH)) ? PAL_DEPTH : {27'd0, cfg_size};
      n    = (cfg_leds == 7'd0) ? 32'd1 :
             (cfg_leds > 7'(LED_MAX)) ? LED_MAX : {25'd0, cfg_leds};
      if (cfg_mode == lpa_pkg::MODE_JUMP) begin
         base = (elapsed / per) % size;
      end else begin
         phase = {32'd0, elapsed % per} * {32'd0, size};
         base  = 32'(phase / {32'd0, per});
      end
      for (int unsigned i = 0; i < n; i++) begin
         sel = (cfg_mode == lpa_pkg::MODE_JUMP) ? base : (base + i) % size;
         c.led_index = 6'(i);
         {c.hue, c.sat, c.val} = pal_model[4'(sel % PAL_DEPTH)];
         c.last_led = (i + 1 == n);
         color_q.push_back(c);
      end
   endfunction

   // Driver. Each request is taken from the pending queue and held until the block
   // accepts it. On acceptance the model is updated in request order. A palette write
   // changes the model palette. A render queues the colors of its frame.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            n_requests++;
            if (in_flight.command == lpa_pkg::CMD_WRITE) begin
               pal_model[in_flight.entry_index] =
                  {in_flight.entry_hue, in_flight.entry_sat, in_flight.entry_val};
            end else begin
               n_frames++;
               predict_leds(in_flight.now_ms);
            end
         end
         // The channel is free when nothing is offered or the offer was just taken.
         // Outside reset, valid is lowered only in this branch, so it is never both dropped and
         // raised within one edge.
         if (!req_valid || req_ready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pend_q.pop_front();
               req_valid       <= 1'b1;
               req_command     <= in_flight.command;
               req_now_ms      <= in_flight.now_ms;
               req_entry_index <= in_flight.entry_index;
               req_entry_hue   <= in_flight.entry_hue;
               req_entry_sat   <= in_flight.entry_sat;
               req_entry_val   <= in_flight.entry_val;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each delivered LED color is checked field by field against the oldest
   // prediction. Ready is chosen anew on every edge according to the stall rate of
   // the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (color_q.size() == 0) begin
               report_mismatch($sformatf("LED %0d delivered with no frame pending",
                                         rsp_led_index));
            end else begin
               want = color_q.pop_front();
               n_leds++;
               if (rsp_led_index !== want.led_index)
                  report_mismatch($sformatf("led_index %0d, expected %0d",
                                            rsp_led_index, want.led_index));
               if (rsp_hue !== want.hue)
                  report_mismatch($sformatf("LED %0d hue %0h, expected %0h",
                                            want.led_index, rsp_hue, want.hue));
               if (rsp_sat !== want.sat)
                  report_mismatch($sformatf("LED %0d sat %0h, expected %0h",
                                            want.led_index, rsp_sat, want.sat));
               if (rsp_val !== want.val)
                  report_mismatch($sformatf("LED %0d val %0h, expected %0h",
                                            want.led_index, rsp_val, want.val));
               if (rsp_last !== want.last_led)
                  report_mismatch($sformatf("LED %0d last %0b, expected %0b",
                                            want.led_index, rsp_last, want.last_led));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // This issues one register write and records it in the model, masked to the width
   // of the register. Indexes beyond the last register must leave every setting as it is.
   task automatic write_csr(input logic [lpa_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         lpa_pkg::REG_MODE:         cfg_mode   = data[0];
         lpa_pkg::REG_PERIOD_MS:    cfg_period = data[15:0];
         lpa_pkg::REG_PALETTE_SIZE: cfg_size   = data[4:0];
         lpa_pkg::REG_LED_COUNT:    cfg_leds   = data[6:0];
         lpa_pkg::REG_START_TIME:   cfg_start  = data;
         default: ;
      endcase
   endtask

   // This writes all five settings plus one write to an unused index. Enable stays high
   // across the run of writes and drops once at the end.
   task automatic set_config(input logic [31:0] mode_v, period_v, size_v, leds_v, start_v);
      write_csr(lpa_pkg::REG_MODE, mode_v);
      write_csr(lpa_pkg::REG_PERIOD_MS, period_v);
      write_csr(lpa_pkg::REG_PALETTE_SIZE, size_v);
      write_csr(lpa_pkg::REG_LED_COUNT, leds_v);
      write_csr(lpa_pkg::REG_START_TIME, start_v);
      write_csr(lpa_pkg::REG_START_TIME + lpa_pkg::CSR_INDEX_W'($urandom_range(1, 3)),
                $urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   // This waits until every queued request has been taken and every predicted color has
   // arrived. The checks run on the falling edge, so all updates from the rising edge
   // have settled. A palette write gives no response, so the task goes on waiting to let
   // a trailing write finish before the settings are touched.
   task automatic drain();
      @(negedge clock);
      while (pend_q.size() != 0 || req_valid || color_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   task automatic push_write(input logic [3:0] idx, input logic [7:0] h, s, v);
      lpa_request_type r;
      r.command     = lpa_pkg::CMD_WRITE;
      r.now_ms      = $urandom;
      r.entry_index = idx;
      r.entry_hue   = h;
      r.entry_sat   = s;
      r.entry_val   = v;
      pend_q.push_back(r);
   endtask

   task automatic push_render(input logic [31:0] now);
      lpa_request_type r;
      r.command     = lpa_pkg::CMD_RENDER;
      r.now_ms      = now;
      r.entry_index = 4'($urandom);
      r.entry_hue   = 8'($urandom);
      r.entry_sat   = 8'($urandom);
      r.entry_val   = 8'($urandom);
      pend_q.push_back(r);
   endtask

   // Byte values lean toward the extremes now and then.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // This queues one phase of random traffic: about a quarter palette rewrites and the
   // rest renders. Render times are chosen in four ways: anywhere in the 32-bit range,
   // somewhere inside a period, right on or just short of a period boundary, or shortly
   // before the start time, so that the elapsed time wraps.
   task automatic run_random_phase(input int unsigned send_pct, hold_pct, count);
      int unsigned per;
      int unsigned m;
      drain();
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      per = (cfg_period == 16'd0) ? 1 : cfg_period;
      for (int unsigned k = 0; k < count; k++) begin
         m = $urandom_range(0, 40);
         if ($urandom_range(99) < 25) begin
            push_write(4'($urandom), pick_byte(), pick_byte(), pick_byte());
         end else begin
            case ($urandom_range(3))
               0: push_render($urandom);
               1: push_render(cfg_start + per * m + $urandom_range(0, per - 1));
               2: push_render(cfg_start + per * m - $urandom_range(0, 1));
               default: push_render(cfg_start - $urandom_range(1, 3 * per));
            endcase
         end
      end
      drain();
   endtask

   // Main sequence.
   initial begin
      cfg_mode   = lpa_pkg::MODE_JUMP;
      cfg_period = lpa_pkg::RST_PERIOD_MS;
      cfg_size   = lpa_pkg::RST_PALETTE_SIZE;
      cfg_leds   = lpa_pkg::RST_LED_COUNT;
      cfg_start  = lpa_pkg::RST_START_TIME;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first under the reset settings. Every palette entry is written
      // before any render, so no frame ever reads an entry that holds garbage. The first
      // entries take all-zero, all-one and alternating colors.
      push_write(4'd0, 8'h00, 8'h00, 8'h00);
      push_write(4'd1, 8'hFF, 8'hFF, 8'hFF);
      push_write(4'd2, 8'hAA, 8'h55, 8'hAA);
      push_write(4'd3, 8'h55, 8'hAA, 8'h55);
      for (int unsigned i = 4; i < PAL_DEPTH; i++) begin
         push_write(4'(i), pick_byte(), pick_byte(), pick_byte());
      end
      push_render(32'h0000_0000);
      push_render(32'hFFFF_FFFF);
      // This rewrites the entry that was just read. The next frame must show the new color.
      push_write(4'd0, 8'h12, 8'h34, 8'h56);
      push_render(32'h0000_0001);
      drain();

      // Next is scroll across a full strip with a short period. The renders fall at zero
      // elapsed time, at a wrapped elapsed time, and at the last millisecond of the period.
      set_config(lpa_pkg::MODE_SCROLL, 32'd7, 32'd16, 32'd64, 32'd100);
      push_render(32'd100);
      push_render(32'd99);
      push_render(32'd106);
      drain();

      // Last comes jump with a one-millisecond period, so the frame index cycles through
      // every entry. The start time sits at the top of the range.
      set_config(lpa_pkg::MODE_JUMP, 32'd1, 32'd16, 32'd3, 32'hFFFF_FFFF);
      push_render(32'hFFFF_FFFE);
      push_render(32'h0000_0000);
      drain();

      // Random phases. The settings walk from the extremes, including the zero and
      // oversized values that must be clamped, to random and raw full-width register
      // data. The idling pattern changes between phases.
      set_config(lpa_pkg::MODE_JUMP, 32'd1, 32'd16, 32'd64, 32'd0);
      run_random_phase(0, 0, 45);
      set_config(lpa_pkg::MODE_SCROLL, 32'd65535, 32'd16, 32'd64, $urandom);
      run_random_phase(59, 0, 45);
      set_config(lpa_pkg::MODE_SCROLL, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      run_random_phase(0, 59, 30);
      set_config(lpa_pkg::MODE_SCROLL, $urandom_range(2, 24), 32'd31, 32'd127, $urandom);
      run_random_phase(17, 17, 45);
      set_config(lpa_pkg::MODE_JUMP, $urandom_range(1, 65535), 32'd17, 32'd65, $urandom);
      run_random_phase(59, 0, 40);
      set_config(lpa_pkg::MODE_SCROLL, $urandom_range(1, 300), $urandom_range(1, 16),
                 $urandom_range(1, 64), $urandom);
      run_random_phase(0, 59, 45);
      set_config(lpa_pkg::MODE_JUMP, $urandom_range(1, 50), $urandom_range(2, 16),
                 $urandom_range(1, 16), $urandom);
      run_random_phase(17, 17, 45);
      set_config(lpa_pkg::MODE_SCROLL, $urandom, $urandom, $urandom, $urandom);
      run_random_phase(0, 0, 45);
      set_config(lpa_pkg::MODE_JUMP, $urandom, $urandom, $urandom, $urandom);
      run_random_phase(17, 17, 40);

      // The final drain is done. Now let the block sit a while so that any stray
      // response shows up as a mismatch.
      repeat (200) @(posedge clock);
      if (color_q.size() != 0) begin
         report_mismatch($sformatf("%0d LED colors never delivered", color_q.size()));
      end
      $display("covered %0d requests, %0d frames, %0d LED colors checked, %0d settings",
               n_requests, n_frames, n_leds, n_settings);
      $display("mismatches: %0d", n_errors);
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: a stuck handshake ends the run here.
   initial begin
      #LIMIT_NS;
      $display("timeout with %0d requests and %0d LED colors outstanding",
               pend_q.size(), color_q.size());
      $display("status: fail");
      $finish;
   end

endmodule
